@@ src/qwt_pkg.sv @@
package qwt_pkg;

  localparam int WORD_CAPACITY = 32;
  localparam int WORD_SLOTS    = 16;
  localparam int MAX_RESULTS   = 32;

  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    is_quote = (c == CHAR_SQUOTE) || (c == CHAR_DQUOTE);
  endfunction

endpackage

@@ src/quoted_word_tokenizer_unit.sv @@
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata[7:0] byte_in
// m_axis   | out | tdata: char_out, word_index, word_end, command_end, word_truncated,
//          |     | words_dropped; tuser: has_char; tlast: run_last
//
// A byte that yields no result is accepted without leaving the idle state. A byte that closes a word
// of n emitted characters passes through the accepting state and a word store read state, then
// yields one character per cycle from the word store read port.
// A marker beat is emitted from the marker state once the closing byte is accepted.
// The input is held off while a word drains; stalls on m_axis hold the drain in place.
// Reset is asynchronous and leaves the block outside any word with an empty command.
module quoted_word_tokenizer_unit #(
  parameter int WORD_CAPACITY = qwt_pkg::WORD_CAPACITY,
  parameter int WORD_SLOTS    = qwt_pkg::WORD_SLOTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] byte_in
  input  logic [qwt_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] char_out, [11:8] word_index, [12] word_end, [13] command_end,
  // [14] word_truncated, [15] words_dropped
  output logic [qwt_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // [0] has_char
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  localparam int LW = $clog2(WORD_CAPACITY + 1);
  localparam int AW = $clog2(WORD_CAPACITY);
  localparam int CW = $clog2(WORD_SLOTS);
  localparam int MaxRes = (qwt_pkg::MAX_RESULTS < WORD_CAPACITY) ?
                          qwt_pkg::MAX_RESULTS : WORD_CAPACITY;
  localparam logic [LW-1:0] MaxResL  = LW'(MaxRes);
  localparam logic [LW-1:0] CapL     = LW'(WORD_CAPACITY);
  localparam logic [CW-1:0] LastSlot = CW'(WORD_SLOTS - 1);

  localparam logic [1:0] MODE_OUT  = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_SQ   = 2'd2;
  localparam logic [1:0] MODE_DQ   = 2'd3;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_MARK = 2'd3;

  logic [7:0] word_mem [WORD_CAPACITY];
  logic [7:0] rd_data_q;
  logic       rd_en;
  logic [AW-1:0] rd_addr;
  logic       wr_en;

  logic [1:0]    state_q, state_d;
  logic [1:0]    mode_q, mode_d;
  logic [LW-1:0] len_q, len_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    final_q, final_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] last_q, last_d;
  logic [3:0]    idx_q, idx_d;
  logic          trunc_q, trunc_d;
  logic          cmd_q, cmd_d;
  logic          drop_q, drop_d;
  logic          mwend_q, mwend_d;

  localparam int OUT_DATA_W_L = qwt_pkg::OUT_DATA_W;
  logic          out_valid_q;
  logic [OUT_DATA_W_L-1:0] out_data_q, out_data_d;
  logic          out_user_q, out_user_d;
  logic          out_last_q, out_last_d;
  logic          out_load;
  logic          out_free;

  logic          in_beat;
  logic [7:0]    b;
  logic          blank;
  logic          term;
  logic          finish;
  logic          full;
  logic          strip;
  logic [LW-1:0] lo, hi, cnt, hi_lim, hi_m1;
  logic [CW+3:0] count_ext;
  logic          at_last;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;
  assign blank           = qwt_pkg::is_blank(b);
  assign term            = (b == qwt_pkg::CHAR_NUL);
  assign finish          = (term && mode_q != MODE_OUT) || (mode_q == MODE_WORD && blank && !term);
  assign full            = (count_q >= LastSlot);
  assign count_ext       = {4'b0, count_q};
  assign at_last         = (ptr_q == last_q);

  // Outer quote stripping is decided from the first and final characters held
  // in registers, so no store read is needed to size the run.
  always_comb begin
    strip  = (ovf_q || len_q >= LW'(2)) && qwt_pkg::is_quote(first_q) && (first_q == final_q);
    lo     = strip ? LW'(1) : LW'(0);
    hi     = len_q - ((strip && !ovf_q) ? LW'(1) : LW'(0));
    cnt    = hi - lo;
    hi_lim = (cnt > MaxResL) ? lo + MaxResL : hi;
    hi_m1  = hi_lim - LW'(1);
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    len_d     = len_q;
    first_d   = first_q;
    final_d   = final_q;
    ovf_d     = ovf_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    ptr_d     = ptr_q;
    last_d    = last_q;
    idx_d     = idx_q;
    trunc_d   = trunc_q;
    cmd_d     = cmd_q;
    drop_d    = drop_q;
    mwend_d   = mwend_q;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = ptr_q;
    out_load  = 1'b0;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    out_last_d = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (finish) begin
            ptr_d   = lo[AW-1:0];
            last_d  = hi_m1[AW-1:0];
            idx_d   = count_ext[3:0];
            trunc_d = ovf_q;
            cmd_d   = term;
            drop_d  = dropped_q || full;
            mwend_d = 1'b1;
            if (full) begin
              dropped_d = 1'b1;
              state_d   = term ? ST_MARK : ST_IDLE;
              idx_d     = 4'd0;
              trunc_d   = 1'b0;
              mwend_d   = 1'b0;
            end else begin
              count_d = count_q + CW'(1);
              state_d = (cnt == LW'(0)) ? ST_MARK : ST_RD;
            end
            mode_d  = MODE_OUT;
            len_d   = '0;
            final_d = 8'h00;
            ovf_d   = 1'b0;
          end else if (term) begin
            ptr_d   = '0;
            last_d  = '0;
            idx_d   = 4'd0;
            trunc_d = 1'b0;
            cmd_d   = 1'b1;
            drop_d  = dropped_q;
            mwend_d = 1'b0;
            state_d = ST_MARK;
          end else if (!(mode_q == MODE_OUT && blank)) begin
            // Append the byte; a fresh word restarts the store at entry zero.
            if (mode_q == MODE_OUT) begin
              len_d   = LW'(1);
              ovf_d   = 1'b0;
              first_d = b;
              wr_en   = 1'b1;
            end else if (len_q < CapL) begin
              len_d = len_q + LW'(1);
              wr_en = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            final_d = b;
            case (mode_q)
              MODE_OUT, MODE_WORD: begin
                if (b == qwt_pkg::CHAR_SQUOTE)      mode_d = MODE_SQ;
                else if (b == qwt_pkg::CHAR_DQUOTE) mode_d = MODE_DQ;
                else                                mode_d = MODE_WORD;
              end
              MODE_SQ: begin
                if (b == qwt_pkg::CHAR_SQUOTE) mode_d = MODE_WORD;
              end
              default: begin
                if (b == qwt_pkg::CHAR_DQUOTE) mode_d = MODE_WORD;
              end
            endcase
          end
          if (term) begin
            mode_d    = MODE_OUT;
            len_d     = '0;
            final_d   = 8'h00;
            ovf_d     = 1'b0;
            count_d   = '0;
            dropped_d = 1'b0;
          end
        end
      end
      ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_q;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = {drop_q && cmd_q && at_last, trunc_q, cmd_q && at_last, at_last,
                        idx_q, rd_data_q};
          out_user_d = 1'b1;
          out_last_d = at_last;
          if (at_last) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d   = ptr_q + AW'(1);
            rd_en   = 1'b1;
            rd_addr = ptr_q + AW'(1);
          end
        end
      end
      default: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = {drop_q && cmd_q, trunc_q, cmd_q, mwend_q, idx_q, 8'h00};
          out_user_d = 1'b0;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      word_mem[len_q[AW-1:0]] <= b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= word_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_OUT;
      len_q       <= '0;
      first_q     <= 8'h00;
      final_q     <= 8'h00;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      len_q     <= len_d;
      first_q   <= first_d;
      final_q   <= final_d;
      ovf_q     <= ovf_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    last_q     <= last_d;
    idx_q      <= idx_d;
    trunc_q    <= trunc_d;
    cmd_q      <= cmd_d;
    drop_q     <= drop_d;
    mwend_q    <= mwend_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  // A terminator always produces at least one result beat.
  a_term_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && term) |=> (state_q != ST_IDLE))
    else $error("terminator accepted without a pending result");

  a_ptr_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (ptr_q <= last_q))
    else $error("emit pointer ran past the last character");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CapL)
    else $error("stored length exceeds word capacity");

  a_cmd_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[13]) |-> out_last_q)
    else $error("command end beat is not the last of its run");

endmodule
